>>> sv/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared definitions for the RPN stack evaluator
// Token and operator codes, error codes, read-port selects and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int VAL_W           = 48;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic TOK_NUM = 1'b0;
    localparam logic TOK_OP  = 1'b1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_FEW  = 3'd1;
    localparam logic [2:0] ERR_LEFT = 3'd2;
    localparam logic [2:0] ERR_DIV0 = 3'd3;
    localparam logic [2:0] ERR_OVF  = 3'd4;

    localparam logic [1:0] RD_BASE = 2'd0;
    localparam logic [1:0] RD_TOP  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    typedef struct packed {
        logic       load_tok;
        logic       push;
        logic       set_err;
        logic [2:0] err_code;
        logic [1:0] rd_sel;
        logic       cap_right;
        logic       start_op;
        logic       mul_step;
        logic       div_step;
        logic       sat;
        logic       wb;
        logic       emit;
    } rse_cmd_t;

    typedef struct packed {
        logic       tok_is_op;
        logic [1:0] op_code;
        logic       tok_last;
        logic       err_set;
        logic       stack_full;
        logic       few_operands;
        logic       right_zero;
        logic       mul_last;
        logic       div_last;
        logic       out_free;
    } rse_sts_t;

endpackage

>>> sv/rpn_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit: postfix expression evaluator, signed Q31.16
// Takes one token per request, keeps operands on a stack and returns one
// result (value or error code) for the token that closes an expression.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------
//  s_       | in        | s_valid / s_ready | s_req_type, s_op_code,
//           |           |                   | s_number_value, s_last_token
//  m_       | out       | m_valid / m_ready | m_result_value, m_error_code
//
//  Push, add/subtract, multiply and divide requests each take their own
//  path; divide runs the one-bit restoring divider loop (64 steps at the
//  default). A closing token's result waits in the output register until
//  taken.
//  Reset (aresetn low, synchronous) empties the stack and clears the error;
//  stack contents are not cleared and need no sweep.
//  A stalled m_ready holds the result; the next request is still taken and
//  only a second closing token waits for the output register to drain.
//
module rpn_stack_evaluator_unit
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [1:0]              s_op_code,
    input  logic signed [VAL_W-1:0] s_number_value,
    input  logic                    s_last_token,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [2:0]              m_error_code
);

    rse_cmd_t cmd;
    rse_sts_t sts;

    // sequencer: decode, fetch operands, run the arithmetic unit, write back
    rse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stack memory, arithmetic units and result register
    rse_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_op_code      (s_op_code),
        .s_number_value (s_number_value),
        .s_last_token   (s_last_token),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_error_code   (m_error_code)
    );

endmodule

>>> sv/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl: token sequencer of the RPN stack evaluator
// Steps each request through decode, operand reads, arithmetic, write-back
// and result delivery by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module rse_ctrl
    import rse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rse_sts_t sts,
    output rse_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RDLEFT = 4'd2;
    localparam logic [3:0] S_EXEC   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_SAT    = 4'd6;
    localparam logic [3:0] S_WB     = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_BASE;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_tok = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                if (!sts.err_set) begin
                    if (!sts.tok_is_op) begin
                        if (sts.stack_full) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ERR_OVF;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end else if (sts.few_operands) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ERR_FEW;
                    end else begin
                        cmd.rd_sel = RD_TOP;
                        state_next = S_RDLEFT;
                    end
                end
            end
            S_RDLEFT: begin
                cmd.cap_right = 1'b1;
                cmd.rd_sel    = RD_NEXT;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                if (sts.op_code == OP_DIV && sts.right_zero) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ERR_DIV0;
                    state_next   = S_FINISH;
                end else begin
                    cmd.start_op = 1'b1;
                    if (sts.op_code inside {OP_ADD, OP_SUB}) begin
                        state_next = S_WB;
                    end else if (sts.op_code == OP_MUL) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) begin
                    state_next = S_SAT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat    = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                cmd.wb     = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                state_next = sts.tok_last ? S_RESULT : S_IDLE;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a request is taken only when no earlier one is still in flight
    a_accept_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_tok |=> state_reg == S_DECODE)
        else $error("request accepted outside idle");

    // an error is recorded only while the expression is still clean
    a_first_error_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_err |-> !sts.err_set)
        else $error("sticky error overwritten");

    // write-back never follows a refused divide
    a_div_zero_skips_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && sts.op_code == OP_DIV && sts.right_zero)
        |=> state_reg == S_FINISH)
        else $error("divide by zero not refused");

endmodule

>>> sv/rse_dpath.sv
// ----------------------------------------------------------------------------
// rse_dpath: operand stack and arithmetic of the RPN stack evaluator
// Holds the stack memory, depth and sticky error, a shared 24x24 multiply
// accumulator, a one-bit-per-cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
module rse_dpath
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rse_cmd_t                cmd,
    output rse_sts_t                sts,
    input  logic                    s_req_type,
    input  logic [1:0]              s_op_code,
    input  logic signed [VAL_W-1:0] s_number_value,
    input  logic                    s_last_token,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [2:0]              m_error_code
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int HW  = VAL_W / 2;
    localparam int PW  = 2 * VAL_W;
    localparam int NW  = VAL_W + FRAC_BITS;
    localparam int ITW = $clog2(NW);

    localparam logic [VAL_W-1:0] LIM_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] LIM_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // token
    logic             tok_type_reg;
    logic [1:0]       tok_op_reg;
    logic [VAL_W-1:0] tok_num_reg;
    logic             tok_last_reg;

    // stack
    logic [VAL_W-1:0] stack_mem [STACK_DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [2:0]       err_reg;
    logic [2:0]       err_next;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wb_addr;
    logic [CW-1:0]    count_m1;
    logic [CW-1:0]    count_m2;
    logic [VAL_W-1:0] rd_data_reg;

    // arithmetic
    logic [VAL_W-1:0] right_reg;
    logic             neg_reg;
    logic [VAL_W-1:0] ma_reg;
    logic [VAL_W-1:0] mb_reg;
    logic [PW-1:0]    wide_reg;
    logic [NW-1:0]    num_sh_reg;
    logic [VAL_W-1:0] rem_reg;
    logic [ITW-1:0]   iter_reg;
    logic [VAL_W-1:0] res_reg;

    logic [VAL_W-1:0] left_mag;
    logic [VAL_W-1:0] right_mag;
    logic signed [VAL_W:0] lx;
    logic signed [VAL_W:0] rx;
    logic signed [VAL_W:0] sum;
    logic [VAL_W-1:0] addsub_res;
    logic [HW-1:0]    pa;
    logic [HW-1:0]    pb;
    logic [VAL_W-1:0] pp;
    logic [PW-1:0]    pp_sh;
    logic [VAL_W:0]   r_sh;
    logic [VAL_W:0]   r_diff;
    logic [PW-1:0]    mag_src;
    logic [VAL_W-1:0] lim;
    logic [VAL_W-1:0] mag_sat;
    logic [VAL_W-1:0] sat_res;
    logic [2:0]       final_err;

    // output register
    logic             m_valid_reg;
    logic [VAL_W-1:0] m_value_reg;
    logic [2:0]       m_err_reg;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign wb_addr  = count_m2[AW-1:0];

    always_comb begin
        case (cmd.rd_sel)
            RD_TOP:  rd_addr = count_m1[AW-1:0];
            RD_NEXT: rd_addr = count_m2[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_tok) begin
            tok_type_reg <= s_req_type;
            tok_op_reg   <= s_op_code;
            tok_num_reg  <= s_number_value;
            tok_last_reg <= s_last_token;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[count_reg[AW-1:0]] <= tok_num_reg;
        end else if (cmd.wb) begin
            stack_mem[wb_addr] <= res_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb begin
        if (err_reg != ERR_NONE) begin
            final_err = err_reg;
        end else if (count_reg > CW'(1)) begin
            final_err = ERR_LEFT;
        end else if (count_reg == '0) begin
            final_err = ERR_FEW;
        end else begin
            final_err = ERR_NONE;
        end
    end

    always_comb begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.wb) begin
            count_next = count_m1;
        end
        if (cmd.set_err) begin
            err_next = cmd.err_code;
        end
        if (cmd.emit) begin
            count_next = '0;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            err_reg   <= ERR_NONE;
        end else begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // operand magnitudes; left comes straight off the read port
    assign left_mag  = rd_data_reg[VAL_W-1] ? (~rd_data_reg + VAL_W'(1)) : rd_data_reg;
    assign right_mag = right_reg[VAL_W-1] ? (~right_reg + VAL_W'(1)) : right_reg;

    // add / subtract with saturation
    assign lx  = signed'({rd_data_reg[VAL_W-1], rd_data_reg});
    assign rx  = signed'({right_reg[VAL_W-1], right_reg});
    assign sum = (tok_op_reg == OP_SUB) ? (lx - rx) : (lx + rx);

    always_comb begin
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            addsub_res = sum[VAL_W] ? LIM_NEG : LIM_POS;
        end else begin
            addsub_res = sum[VAL_W-1:0];
        end
    end

    // one half-width partial product per cycle
    assign pa = iter_reg[1] ? ma_reg[VAL_W-1:HW] : ma_reg[HW-1:0];
    assign pb = iter_reg[0] ? mb_reg[VAL_W-1:HW] : mb_reg[HW-1:0];
    assign pp = pa * pb;

    always_comb begin
        case (iter_reg[1:0])
            2'd0:    pp_sh = PW'(pp);
            2'd3:    pp_sh = PW'(pp) << VAL_W;
            default: pp_sh = PW'(pp) << HW;
        endcase
    end

    // restoring divide step
    assign r_sh   = {rem_reg, num_sh_reg[NW-1]};
    assign r_diff = r_sh - {1'b0, mb_reg};

    // saturate the magnitude, then restore the sign
    assign mag_src = (tok_op_reg == OP_DIV) ? wide_reg : (wide_reg >> FRAC_BITS);
    assign lim     = neg_reg ? LIM_NEG : LIM_POS;

    always_comb begin
        if ((|mag_src[PW-1:VAL_W]) || (mag_src[VAL_W-1:0] > lim)) begin
            mag_sat = lim;
        end else begin
            mag_sat = mag_src[VAL_W-1:0];
        end
        sat_res = neg_reg ? (~mag_sat + VAL_W'(1)) : mag_sat;
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_right) begin
            right_reg <= rd_data_reg;
        end
        if (cmd.start_op) begin
            neg_reg    <= rd_data_reg[VAL_W-1] ^ right_reg[VAL_W-1];
            ma_reg     <= left_mag;
            mb_reg     <= right_mag;
            wide_reg   <= '0;
            rem_reg    <= '0;
            num_sh_reg <= NW'(left_mag) << FRAC_BITS;
            iter_reg   <= '0;
            res_reg    <= addsub_res;
        end
        if (cmd.mul_step) begin
            wide_reg <= wide_reg + pp_sh;
            iter_reg <= iter_reg + ITW'(1);
        end
        if (cmd.div_step) begin
            num_sh_reg <= num_sh_reg << 1;
            iter_reg   <= iter_reg + ITW'(1);
            if (!r_diff[VAL_W]) begin
                rem_reg  <= r_diff[VAL_W-1:0];
                wide_reg <= {wide_reg[PW-2:0], 1'b1};
            end else begin
                rem_reg  <= r_sh[VAL_W-1:0];
                wide_reg <= {wide_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.sat) begin
            res_reg <= sat_res;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_value_reg <= (final_err == ERR_NONE) ? rd_data_reg : '0;
            m_err_reg   <= final_err;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_error_code   = m_err_reg;

    assign sts.tok_is_op    = (tok_type_reg == TOK_OP);
    assign sts.op_code      = tok_op_reg;
    assign sts.tok_last     = tok_last_reg;
    assign sts.err_set      = (err_reg != ERR_NONE);
    assign sts.stack_full   = (count_reg >= CW'(STACK_DEPTH));
    assign sts.few_operands = (count_reg < CW'(2));
    assign sts.right_zero   = (right_reg == '0);
    assign sts.mul_last     = (iter_reg[1:0] == 2'd3);
    assign sts.div_last     = (iter_reg == ITW'(NW - 1));
    assign sts.out_free     = !m_valid_reg || m_ready;

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack depth out of range");

    a_wb_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |-> count_reg >= CW'(2))
        else $error("write-back with fewer than two operands");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> count_reg == '0 && err_reg == ERR_NONE && m_valid_reg)
        else $error("expression state not cleared after result");

endmodule

>>> tb/sv/rpn_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_result_checker: result predictor and scoreboard for the RPN evaluator
// Evaluates each accepted token on its own operand stack. It queues one
// expected result per closing token and compares every accepted result
// against the oldest one in the queue.
// ----------------------------------------------------------------------------
module rpn_result_checker
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [1:0]              s_op_code,
    input  logic signed [VAL_W-1:0] s_number_value,
    input  logic                    s_last_token,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [VAL_W-1:0] m_result_value,
    input  logic [2:0]              m_error_code,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [2:0]       code;
    } rpn_result_t;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic [VAL_W-1:0] operands [STACK_DEPTH];
    int unsigned      operand_cnt;
    logic [2:0]       expr_error;
    rpn_result_t      expected_results [$];

    initial begin
        fail_count  = 0;
        pending     = 0;
        operand_cnt = 0;
        expr_error  = ERR_NONE;
    end

    // Saturate a wide magnitude with a sign to the value range.
    function automatic logic [VAL_W-1:0] clamp_mag(input logic neg, input logic [127:0] mag);
        logic [127:0]     lim;
        logic [VAL_W-1:0] m;
        lim = neg ? (128'd1 << (VAL_W - 1)) : ((128'd1 << (VAL_W - 1)) - 128'd1);
        if (mag > lim) mag = lim;
        m = mag[VAL_W-1:0];
        return neg ? (48'd0 - m) : m;
    endfunction

    function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic subtract);
        logic signed [VAL_W:0] s;
        if (subtract) s = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
        else          s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] fx_product(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] ma, mb;
        logic [127:0]     p;
        ma = a[VAL_W-1] ? (48'd0 - a) : a;
        mb = b[VAL_W-1] ? (48'd0 - b) : b;
        p  = {80'd0, ma} * {80'd0, mb};
        return clamp_mag(a[VAL_W-1] ^ b[VAL_W-1], p >> FRAC_BITS);
    endfunction

    function automatic logic [VAL_W-1:0] fx_quotient(input logic [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] ma, mb;
        logic [127:0]     n;
        ma = a[VAL_W-1] ? (48'd0 - a) : a;
        mb = b[VAL_W-1] ? (48'd0 - b) : b;
        n  = {80'd0, ma} << FRAC_BITS;
        return clamp_mag(a[VAL_W-1] ^ b[VAL_W-1], n / {80'd0, mb});
    endfunction

    // Apply one token to the operand stack; queue a result on a closing token.
    task automatic eval_token(input logic kind, input logic [1:0] op,
                              input logic [VAL_W-1:0] num, input logic last);
        logic [VAL_W-1:0] lhs, rhs, res;
        logic             done;
        rpn_result_t      r;
        if (expr_error == ERR_NONE) begin
            if (kind == TOK_NUM) begin
                if (operand_cnt >= STACK_DEPTH) begin
                    expr_error = ERR_OVF;
                end else begin
                    operands[operand_cnt] = num;
                    operand_cnt++;
                end
            end else if (operand_cnt < 2) begin
                expr_error = ERR_FEW;
            end else begin
                rhs  = operands[operand_cnt-1];
                lhs  = operands[operand_cnt-2];
                done = 1'b1;
                res  = '0;
                case (op)
                    OP_ADD: res = sat_sum(lhs, rhs, 1'b0);
                    OP_SUB: res = sat_sum(lhs, rhs, 1'b1);
                    OP_MUL: res = fx_product(lhs, rhs);
                    default: begin
                        if (rhs == '0) begin
                            expr_error = ERR_DIV0;
                            done       = 1'b0;
                        end else begin
                            res = fx_quotient(lhs, rhs);
                        end
                    end
                endcase
                if (done) begin
                    operand_cnt--;
                    operands[operand_cnt-1] = res;
                end
            end
        end
        if (last) begin
            r.code  = expr_error;
            r.value = '0;
            if (expr_error == ERR_NONE) begin
                if (operand_cnt > 1)       r.code  = ERR_LEFT;
                else if (operand_cnt == 0) r.code  = ERR_FEW;
                else                       r.value = operands[0];
            end
            expected_results = {expected_results, r};
            operand_cnt = 0;
            expr_error  = ERR_NONE;
        end
    endtask

    always @(posedge aclk) begin
        rpn_result_t want;
        if (!aresetn) begin
            operand_cnt = 0;
            expr_error  = ERR_NONE;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                eval_token(s_req_type, s_op_code, s_number_value, s_last_token);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with none expected: result_value %0d error_code %0d",
                           m_result_value, m_error_code);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_value !== want.value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               $signed(want.value), m_result_value);
                        fail_count++;
                    end
                    if (m_error_code !== want.code) begin
                        $error("error_code mismatch: expected %0d, actual %0d",
                               want.code, m_error_code);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/sv/tb_rpn_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator_unit: regression for the RPN stack evaluator
// Drives directed expressions covering saturation, every operator and the
// few-operand, left-over and divide-by-zero errors, then random expressions,
// mostly well formed, with overflow, broken and noise expressions mixed in. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator_unit;
    import rse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 700;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic             kind;
        logic [1:0]       op;
        logic [VAL_W-1:0] val;
    } token_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_req_type     = TOK_NUM;
    logic [1:0]              s_op_code      = OP_ADD;
    logic signed [VAL_W-1:0] s_number_value = '0;
    logic                    s_last_token   = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [VAL_W-1:0] m_result_value;
    logic [2:0]              m_error_code;

    int     fail_count;
    int     pending;
    int     cycle_cnt = 0;
    int     sent_cnt  = 0;
    bit     gaps_on   = 1'b1;
    token_t expr_q [$];

    always #5 aclk = ~aclk;

    rpn_stack_evaluator_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_op_code      (s_op_code),
        .s_number_value (s_number_value),
        .s_last_token   (s_last_token),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_error_code   (m_error_code)
    );

    rpn_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_op_code      (s_op_code),
        .s_number_value (s_number_value),
        .s_last_token   (s_last_token),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_error_code   (m_error_code),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Stall the result channel about a quarter of the time while gaps are on.
    // gaps_on only changes right after a rising edge, so no race here.
    always @(negedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
    end

    // Hard stop on a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("rpn_stack_evaluator_unit regression: fail");
            $finish;
        end
    end

    // Mix of zero, extremes, small Q16 integers, small fractions and raw bits.
    function automatic logic [VAL_W-1:0] rand_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_MAX;
            2:       return VAL_MIN;
            3:       return 48'(signed'($urandom_range(0, 200)) - 100) << DEF_FRAC_BITS;
            4, 5:    return {{24{raw[23]}}, raw[23:0]};
            default: return raw[VAL_W-1:0];
        endcase
    endfunction

    task automatic add_push(input logic [VAL_W-1:0] v);
        token_t t;
        t.kind = TOK_NUM;
        t.op   = 2'($urandom_range(0, 3));   // ignored on a push: randomize anyway
        t.val  = v;
        expr_q = {expr_q, t};
    endtask

    task automatic add_oper(input logic [1:0] op);
        token_t t;
        t.kind = TOK_OP;
        t.op   = op;
        t.val  = VAL_W'({$urandom, $urandom});   // ignored on an operator
        expr_q = {expr_q, t};
    endtask

    // Present one request; hold it until the rising edge that accepts it.
    task automatic send_token(input token_t t, input logic last);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= t.kind;
        s_op_code      <= t.op;
        s_number_value <= t.val;
        s_last_token   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send the queued expression, marking its final token as last.
    task automatic flush_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_token(expr_q[i], i == expr_q.size() - 1);
        sent_cnt += expr_q.size();
        expr_q.delete();
    endtask

    // Build one random expression: mostly well formed, some broken or noise.
    task automatic build_random_expr();
        int kind_sel;
        int n_push;
        int n_done;
        int level;
        kind_sel = $urandom_range(0, 99);
        if (kind_sel < 5) begin
            // noise: arbitrary tokens
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1)) add_oper(2'($urandom_range(0, 3)));
                else                      add_push(rand_value());
            end
        end else if (kind_sel < 12) begin
            // overflow: push past the stack depth, then reduce
            n_push = DEF_STACK_DEPTH + 1 + $urandom_range(0, 2);
            repeat (n_push) add_push(rand_value());
            repeat (n_push - 1) add_oper(2'($urandom_range(0, 3)));
        end else begin
            n_push = ($urandom_range(0, 3) == 0) ? $urandom_range(6, DEF_STACK_DEPTH)
                                                 : $urandom_range(1, 5);
            n_done = 0;
            level  = 0;
            while (!(n_done == n_push && level == 1)) begin
                if (n_done < n_push && (level < 2 || $urandom_range(0, 1))) begin
                    add_push(rand_value());
                    n_done++;
                    level++;
                end else begin
                    add_oper(2'($urandom_range(0, 3)));
                    level--;
                end
            end
            // break a few: one operator too many, or one value left over
            if (kind_sel >= 94)      add_oper(2'($urandom_range(0, 3)));
            else if (kind_sel >= 88) add_push(rand_value());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes as single-token expressions
        add_push(VAL_MAX);
        flush_expr();
        add_push(VAL_MIN);
        flush_expr();

        // saturating add and subtract, then an exact add of the two extremes
        add_push(VAL_MIN);
        add_push(VAL_MIN);
        add_oper(OP_ADD);
        add_push(VAL_MAX);
        add_push(VAL_MIN);
        add_oper(OP_SUB);
        add_oper(OP_ADD);
        flush_expr();

        // 2.0 * 3.5 / -3.0
        add_push(48'h2_0000);
        add_push(48'h3_8000);
        add_oper(OP_MUL);
        add_push(48'hFFFF_FFFD_0000);
        add_oper(OP_DIV);
        flush_expr();

        // divide by zero; the tokens after it must be ignored
        add_push(48'h7_0000);
        add_push('0);
        add_oper(OP_DIV);
        add_push(48'h5_0000);
        add_oper(OP_ADD);
        flush_expr();

        // operator with an empty stack
        add_oper(OP_ADD);
        flush_expr();

        // values left over at the closing token
        add_push(48'h1_0000);
        add_push(48'h2_0000);
        flush_expr();

        // multiply saturation
        add_push(VAL_MIN);
        add_push(VAL_MIN);
        add_oper(OP_MUL);
        flush_expr();

        // random part: a long stretch with no stalls in the middle
        sent_cnt = 0;
        while (sent_cnt < RAND_ITEMS) begin
            gaps_on = !(sent_cnt >= 250 && sent_cnt < 450);
            build_random_expr();
            flush_expr();
        end
        gaps_on = 1'b1;

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then let the divider latency pass before the verdict
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (fail_count == 0) begin
            $display("rpn_stack_evaluator_unit regression: pass");
        end else begin
            $display("rpn_stack_evaluator_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rse_pkg.sv
sv/rse_ctrl.sv
sv/rse_dpath.sv
sv/rpn_stack_evaluator_unit.sv
tb/sv/rpn_result_checker.sv
tb/sv/tb_rpn_stack_evaluator_unit.sv
